// File: src/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and round functions of the AES-128 encrypt unit.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int ROUND_COUNT = 10;
   localparam int STAGE_COUNT = ROUND_COUNT + 1;

   localparam logic [7:0] GF_POLY = 8'h1B;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      unique case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic block_type next_key(input block_type rk, input logic [7:0] rc);
      block_type  nk;
      logic [7:0] g [4];
      g[0] = sbox(get_byte(rk, 13)) ^ rc;
      g[1] = sbox(get_byte(rk, 14));
      g[2] = sbox(get_byte(rk, 15));
      g[3] = sbox(get_byte(rk, 12));
      for (int i = 0; i < 4; i++) begin
         nk[127 - 8*i -: 8] = get_byte(rk, i) ^ g[i];
      end
      for (int i = 4; i < 16; i++) begin
         nk[127 - 8*i -: 8] = get_byte(rk, i) ^ nk[127 - 8*(i-4) -: 8];
      end
      return nk;
   endfunction

   function automatic block_type round_fn(input block_type st, input logic last);
      block_type  t;
      block_type  m;
      logic [7:0] a [4];
      logic [7:0] d [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = sbox(get_byte(st, (4*((c + r) % 4) + r) % 16));
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r] = get_byte(t, 4*c + r);
            d[r] = gf_double(a[r]);
         end
         m[127 - 8*(4*c)     -: 8] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
         m[127 - 8*(4*c + 1) -: 8] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
         m[127 - 8*(4*c + 2) -: 8] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
         m[127 - 8*(4*c + 3) -: 8] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
      end
      return last ? t : m;
   endfunction

endpackage
`default_nettype wire

// File: src/aes128_block_encrypt_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// Pipelined AES-128 encryption, one round per stage, one block per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / payload
//  req     | in        | plain_high [63:0], plain_low [127:64]
//  rsp     | out       | cipher_high [63:0], cipher_low [127:64]
//  csr     | in        | index 0 key_high, index 1 key_low, 64-bit data
//
// Key add stage plus ten round stages, one block per cycle while the output is not stalled.
// The pipeline advances as a whole when the output stage is empty or taken.
// Reset clears all valid bits and both key registers to zero.
// A stall holds every stage; nothing is lost or repeated.
module aes128_block_encrypt_unit import aes_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // plain_high, plain_low
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // cipher_high, cipher_low
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [63:0]  csr_data
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;
   logic        valid0_ff;
   block_type   state0_ff, key0_ff;
   logic        sv [STAGE_COUNT];
   block_type   ss [STAGE_COUNT];
   block_type   sk [STAGE_COUNT];
   logic [7:0]  rc [ROUND_COUNT];

   assign advance    = !sv[STAGE_COUNT-1] || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         valid0_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_KEY_HIGH: key_high_ff <= csr_data;
               CSR_KEY_LOW:  key_low_ff  <= csr_data;
               default:      key_high_ff <= key_high_ff;
            endcase
         end
         if (advance) valid0_ff <= req_tvalid;
      end
      if (advance) begin
         // initial AddRoundKey
         state0_ff <= {req_tdata[63:0], req_tdata[127:64]} ^ {key_high_ff, key_low_ff};
         key0_ff   <= {key_high_ff, key_low_ff};
      end
   end

   assign sv[0] = valid0_ff;
   assign ss[0] = state0_ff;
   assign sk[0] = key0_ff;

   always_comb begin
      rc[0] = RCON_FIRST;
      for (int i = 1; i < ROUND_COUNT; i++) rc[i] = gf_double(rc[i-1]);
   end

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      aes_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .last      (r == ROUND_COUNT - 1),
         .rcon      (rc[r]),
         .in_valid  (sv[r]),
         .in_state  (ss[r]),
         .in_key    (sk[r]),
         .out_valid (sv[r+1]),
         .out_state (ss[r+1]),
         .out_key   (sk[r+1])
      );
   end

   assign rsp_tvalid = sv[STAGE_COUNT-1];
   assign rsp_tdata  = {ss[STAGE_COUNT-1][63:0], ss[STAGE_COUNT-1][127:64]};

`ifndef ASSERT_OFF
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");
   a_first_valid: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid0_ff)
      else $error("accepted beat lost at key add stage");
`endif

endmodule
`default_nettype wire

// File: src/aes_round_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round_stage
// One registered cipher round with its round key expansion.
// ----------------------------------------------------------------------------
module aes_round_stage import aes_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      last,
   input  wire logic [7:0] rcon,
   input  wire logic      in_valid,
   input  wire block_type in_state,
   input  wire block_type in_key,
   output logic           out_valid,
   output block_type      out_state,
   output block_type      out_key
);

   logic      valid_ff;
   block_type state_ff, state_in;
   block_type key_ff, key_in;

   always_comb begin
      key_in   = next_key(in_key, rcon);
      state_in = round_fn(in_state, last) ^ key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key   = key_ff;

endmodule
`default_nettype wire

// File: tb/aes128_block_encrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_checker
// Watches the key writes, plaintext beats and ciphertext beats of the AES-128
// encrypt unit, predicts each ciphertext with its own cipher model and
// compares it in order against the observed result beats.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_checker import aes_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic         csr_index,
   input  wire logic [63:0]  csr_data,
   output int                error_count,
   output int                pending_count
);

   logic [7:0] sub_lut [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   logic [63:0]  key_high_q, key_low_q;
   logic [127:0] cipher_queue [$];

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] plain,
                                                  input logic [127:0] key);
      logic [7:0] st [16];
      logic [7:0] rk [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, g0, g1, g2, g3, rc;
      logic [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         st[i] = plain[127 - 8*i -: 8] ^ key[127 - 8*i -: 8];
         rk[i] = key[127 - 8*i -: 8];
      end
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               t[4*c + w] = sub_lut[st[(4*((c + w) % 4) + w) % 16]];
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
               t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
               t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
               t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
         end
         g0 = sub_lut[rk[13]] ^ rc;
         g1 = sub_lut[rk[14]];
         g2 = sub_lut[rk[15]];
         g3 = sub_lut[rk[12]];
         rk[0] ^= g0; rk[1] ^= g1; rk[2] ^= g2; rk[3] ^= g3;
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rc = xtime(rc);
         for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
      return res;
   endfunction

   assign pending_count = cipher_queue.size();

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         key_high_q  <= '0;
         key_low_q   <= '0;
         error_count <= 0;
         cipher_queue.delete();
      end else begin
         // tdata: low half = plain_high, high half = plain_low
         if (req_tvalid && req_tready)
            cipher_queue.push_back(encrypt_block({req_tdata[63:0], req_tdata[127:64]},
                                                 {key_high_q, key_low_q}));
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_queue.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: unexpected cipher beat %h", rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_tdata[63:0] !== want[127:64] || rsp_tdata[127:64] !== want[63:0]) begin
                  if (error_count < 10)
                     $display("ERROR: cipher_high exp %h got %h, cipher_low exp %h got %h",
                              want[127:64], rsp_tdata[63:0], want[63:0], rsp_tdata[127:64]);
                  error_count <= error_count + 1;
               end
            end
         end
         // key write takes effect from the next beat on
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEY_HIGH) key_high_q <= csr_data;
            else key_low_q <= csr_data;
         end
      end
   end

endmodule

// File: tb/tb_aes128_block_encrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_unit
// Drives keys and plaintext blocks into the AES-128 encrypt unit with random
// gaps and output stalls, including a long back-pressure stretch, and reports
// the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_unit;
   import aes_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = CSR_KEY_HIGH;
   logic [63:0]  csr_data = '0;
   int           error_count, pending_count;
   bit           hold_off = 0;

   always #5 clock = ~clock;

   aes128_block_encrypt_unit DUT (.*);

   aes128_block_encrypt_checker checker_i (.*);

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic write_key(input logic idx, input logic [63:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit gaps);
      int g;
      req_tvalid <= 1;
      // plain_high in the low half
      req_tdata <= {lo, hi};
      do @(posedge clock); while (!req_tready);
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_blocks(input int n, input bit gaps);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: send_block('0, {$urandom, $urandom}, gaps);
            1: send_block({$urandom, $urandom}, '1, gaps);
            default: send_block({$urandom, $urandom}, {$urandom, $urandom}, gaps);
         endcase
      end
   endtask

   // receiver: random stalls, and a constant stall while the long hold-off is on
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 0;
      else if ($urandom_range(0, 3) == 0) rsp_tready <= ($urandom_range(0, 9) == 0);
      else rsp_tready <= 1;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset key of zero, extremes of the data
      send_block('0, '0, 0);
      send_block('1, '1, 0);
      send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff, 0);
      send_block(64'h80000000_00000000, 64'h00000000_00000001, 0);
      drain();
      // standard key, then all-ones key, each with an alternating pattern among its data
      write_key(CSR_KEY_HIGH, 64'h00010203_04050607);
      write_key(CSR_KEY_LOW, 64'h08090a0b_0c0d0e0f);
      send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff, 0);
      send_block('0, '0, 0);
      send_block(64'haaaaaaaa_aaaaaaaa, 64'h55555555_55555555, 0);
      drain();
      write_key(CSR_KEY_HIGH, '1);
      write_key(CSR_KEY_LOW, '1);
      send_block('0, '0, 0);
      send_block('1, '1, 0);
      send_block(64'h55555555_55555555, 64'haaaaaaaa_aaaaaaaa, 0);
      drain();
      // back-pressure: fill the pipeline with the output stalled, so that the input stalls
      write_key(CSR_KEY_HIGH, {$urandom, $urandom});
      write_key(CSR_KEY_LOW, {$urandom, $urandom});
      hold_off <= 1;
      fork
         begin
            repeat (60) @(posedge clock);
            hold_off <= 0;
         end
         random_blocks(40, 0);
      join
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         write_key(CSR_KEY_HIGH, phase == 0 ? 64'h0 : {$urandom, $urandom});
         write_key(CSR_KEY_LOW, phase == 1 ? '1 : {$urandom, $urandom});
         random_blocks(90, 1);
         drain();
      end
      if (error_count == 0)
         $display("aes128_block_encrypt_unit regression: pass");
      else
         $display("aes128_block_encrypt_unit regression: fail");
      $finish;
   end

   initial begin
      #2ms;
      $display("aes128_block_encrypt_unit regression: fail");
      $finish;
   end

endmodule
